[src/lpg_pkg.sv]
// Shared types and constants of the lexicographic permutation generator.
// No dependencies; read by the channel interfaces and the top level.
package lpg_pkg;

	// One permutation element holds its value minus one in four bits
	localparam int ELEM_W = 4;
	// Packed permutation word, sixteen elements at most
	localparam int WORD_W = 64;
	// Length register width and its value after reset
	localparam int LEN_W = 5;
	localparam logic [LEN_W-1:0] LEN_RESET = 5'd6;

	typedef logic [ELEM_W-1:0] elem_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [WORD_W-1:0] word_t;

endpackage

[src/lpg_channels.sv]
// Valid/ready channel interfaces of the permutation generator: request,
// response and length configuration. Depends on lpg_pkg.

interface lpg_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source(output valid, output restart, input ready);
	modport sink(input valid, input restart, output ready);
endinterface

interface lpg_rsp_if;
	logic                valid;
	logic                ready;
	lpg_pkg::word_t      permutation_word;
	logic                is_final;
	logic                exhausted;

	modport source(output valid, output permutation_word, output is_final,
		output exhausted, input ready);
	modport sink(input valid, input permutation_word, input is_final,
		input exhausted, output ready);
endinterface

interface lpg_cfg_if;
	logic          valid;
	logic          ready;
	lpg_pkg::len_t length;

	modport source(output valid, output length, input ready);
	modport sink(input valid, input length, output ready);
endinterface

[src/lex_permutation_generator.sv]
// Lexicographic permutation generator, top level.
// Depends on lpg_pkg and the channel interfaces in lpg_channels.sv.
//
// Each request word returns the current permutation of 1..length (element k,
// value minus one, in bits 4k+3..4k, unused elements zero) and then steps the
// stored order to its lexicographic successor. The last, descending order
// comes back with is_final set; later requests answer exhausted with a zero
// word until restart, or a write of length, reloads the identity. The order
// lives in a small memory with one write port and two registered read ports,
// and two comparators walk it. A request passes through an accept step, the
// rightmost-ascent scan, the search for the swap partner, the swap, the
// suffix reversal when the suffix holds two or more elements, and the load
// of the response register. A descending order goes from the scan straight
// to the load, and an exhausted answer or a length of one from accept to the
// load. The load waits while the response register still holds an unaccepted
// word. The block takes no request while it works, but the response register
// lets the next request start while the previous word waits. The identity
// reload is immediate: per-entry valid bits make unwritten entries read as
// their index.

module lex_permutation_generator #(
	parameter int MAX_ELEMENTS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	lpg_req_if.sink          req,
	lpg_rsp_if.source        rsp,
	lpg_cfg_if.sink          cfg
);

	localparam int EW     = lpg_pkg::ELEM_W;
	localparam int IDX_W  = $clog2(MAX_ELEMENTS);
	localparam int PERM_W = MAX_ELEMENTS * EW;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_P,
		ST_SCAN_S,
		ST_SWAP,
		ST_REV_RD,
		ST_REV_W1,
		ST_REV_W2,
		ST_EMIT
	} state_t;

	state_t state_q;

	// Order memory with valid bits; invalid entries read as identity
	lpg_pkg::elem_t order_mem [MAX_ELEMENTS];
	logic [MAX_ELEMENTS-1:0] valid_q;
	logic [PERM_W-1:0]       word_q;

	lpg_pkg::len_t len_q;
	logic          done_q;

	idx_t          q_q, pq_q, p_q, sq_q, lo_q, hi_q;
	logic          pend_q;
	lpg_pkg::elem_t piv_q;
	lpg_pkg::elem_t rd_a_q, rd_b_q;

	lpg_pkg::word_t res_word_q;
	logic           res_final_q, res_exh_q;

	logic           out_v_q;
	lpg_pkg::word_t out_word_q;
	logic           out_final_q, out_exh_q;

	// Read and write port controls
	logic           rd_en;
	idx_t           ra, rb;
	logic           wr_en;
	idx_t           wr_addr;
	lpg_pkg::elem_t wr_data;

	logic [PERM_W-1:0] ident;
	logic [PERM_W-1:0] word_cur, word_mask;
	idx_t              last_idx;
	logic              req_acc, cfg_acc, rsp_acc;
	logic              eff_done;
	logic              asc_hit, succ_hit;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign req_acc   = req.valid && req.ready;
	assign cfg_acc   = cfg.valid && cfg.ready;
	assign rsp_acc   = rsp.valid && rsp.ready;

	assign rsp.valid            = out_v_q;
	assign rsp.permutation_word = out_word_q;
	assign rsp.is_final         = out_final_q;
	assign rsp.exhausted        = out_exh_q;

	// Last used index: length clamped to 1..MAX_ELEMENTS, minus one
	always_comb begin
		if (len_q == '0) begin
			last_idx = '0;
		end else if (len_q > lpg_pkg::LEN_W'(MAX_ELEMENTS)) begin
			last_idx = IDX_W'(MAX_ELEMENTS - 1);
		end else begin
			last_idx = IDX_W'(len_q - 1'b1);
		end
	end

	// Identity order and the masked word handed out on a request
	always_comb begin
		for (int k = 0; k < MAX_ELEMENTS; k++) begin
			ident[k*EW +: EW] = EW'(k);
		end
	end

	assign word_cur = req.restart ? ident : word_q;

	always_comb begin
		for (int k = 0; k < MAX_ELEMENTS; k++) begin
			word_mask[k*EW +: EW] = (IDX_W'(k) <= last_idx) ? word_cur[k*EW +: EW] : '0;
		end
	end

	assign eff_done = done_q && !req.restart;
	assign asc_hit  = pend_q && (rd_a_q < rd_b_q);
	assign succ_hit = pend_q && (rd_a_q > piv_q);

	// Port addressing per sequencer step
	always_comb begin
		rd_en   = 1'b0;
		ra      = q_q;
		rb      = q_q;
		wr_en   = 1'b0;
		wr_addr = p_q;
		wr_data = rd_a_q;
		unique case (state_q)
			ST_SCAN_P: begin
				rd_en = 1'b1;
				ra    = q_q - 1'b1;
				rb    = q_q;
			end
			ST_SCAN_S: begin
				rd_en   = 1'b1;
				wr_en   = succ_hit;
				wr_addr = p_q;
				wr_data = rd_a_q;
			end
			ST_SWAP: begin
				wr_en   = 1'b1;
				wr_addr = sq_q;
				wr_data = piv_q;
			end
			ST_REV_RD: begin
				rd_en = 1'b1;
				ra    = lo_q;
				rb    = hi_q;
			end
			ST_REV_W1: begin
				wr_en   = 1'b1;
				wr_addr = lo_q;
				wr_data = rd_b_q;
			end
			ST_REV_W2: begin
				rd_en   = 1'b1;
				ra      = lo_q + 1'b1;
				rb      = hi_q - 1'b1;
				wr_en   = 1'b1;
				wr_addr = hi_q;
				wr_data = rd_a_q;
			end
			default: begin
			end
		endcase
	end

	// Memory array: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			order_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= valid_q[ra] ? order_mem[ra] : EW'(ra);
			rd_b_q <= valid_q[rb] ? order_mem[rb] : EW'(rb);
		end
	end

	// Sequencer, stored order shadow and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			word_q      <= ident;
			len_q       <= lpg_pkg::LEN_RESET;
			done_q      <= 1'b0;
			pend_q      <= 1'b0;
			out_v_q     <= 1'b0;
			res_final_q <= 1'b0;
			res_exh_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr]         <= 1'b1;
				word_q[wr_addr*EW +: EW] <= wr_data;
			end
			if (rsp_acc) begin
				out_v_q <= 1'b0;
			end
			if (cfg_acc) begin
				len_q   <= cfg.length;
				valid_q <= '0;
				word_q  <= ident;
				done_q  <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						if (req.restart) begin
							valid_q <= '0;
							word_q  <= ident;
							done_q  <= 1'b0;
						end
						res_final_q <= 1'b0;
						res_exh_q   <= eff_done;
						q_q         <= last_idx;
						pend_q      <= 1'b0;
						if (eff_done) begin
							res_word_q <= '0;
							state_q    <= ST_EMIT;
						end else begin
							res_word_q <= lpg_pkg::WORD_W'(word_mask);
							if (last_idx == '0) begin
								res_final_q <= 1'b1;
								done_q      <= 1'b1;
								state_q     <= ST_EMIT;
							end else begin
								state_q <= ST_SCAN_P;
							end
						end
					end
				end
				ST_SCAN_P: begin
					q_q    <= q_q - 1'b1;
					pq_q   <= q_q;
					pend_q <= 1'b1;
					if (asc_hit) begin
						p_q     <= pq_q - 1'b1;
						piv_q   <= rd_a_q;
						q_q     <= last_idx;
						pend_q  <= 1'b0;
						state_q <= ST_SCAN_S;
					end else if (pend_q && pq_q == idx_t'(1)) begin
						res_final_q <= 1'b1;
						done_q      <= 1'b1;
						state_q     <= ST_EMIT;
					end
				end
				ST_SCAN_S: begin
					q_q    <= q_q - 1'b1;
					pq_q   <= q_q;
					pend_q <= 1'b1;
					if (succ_hit) begin
						sq_q    <= pq_q;
						state_q <= ST_SWAP;
					end
				end
				ST_SWAP: begin
					lo_q <= p_q + 1'b1;
					hi_q <= last_idx;
					if ((p_q + 1'b1) < last_idx) begin
						state_q <= ST_REV_RD;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_REV_RD: begin
					state_q <= ST_REV_W1;
				end
				ST_REV_W1: begin
					state_q <= ST_REV_W2;
				end
				ST_REV_W2: begin
					lo_q <= lo_q + 1'b1;
					hi_q <= hi_q - 1'b1;
					if ((lo_q + 1'b1) < (hi_q - 1'b1)) begin
						state_q <= ST_REV_W1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!out_v_q || rsp.ready) begin
						out_v_q     <= 1'b1;
						out_word_q  <= res_word_q;
						out_final_q <= res_final_q;
						out_exh_q   <= res_exh_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// An exhausted word carries no permutation and no final mark
	a_exh_word: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.exhausted) |-> (rsp.permutation_word == '0 && !rsp.is_final))
		else $error("exhausted response with nonzero payload");

	// A length write reloads the identity: every entry reads as its index
	a_cfg_reload: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_acc |=> (valid_q == '0 && done_q == 1'b0))
		else $error("length write did not reload identity");

	// The swap partner always lies right of the pivot
	a_succ_right: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_S && pend_q) |-> (pq_q > p_q))
		else $error("successor search passed the pivot");

	// Reversal writes only while the pair has not met
	a_rev_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REV_W1) |-> (lo_q < hi_q))
		else $error("suffix reversal pointers crossed");

	// The response register is never overwritten while it still waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_v_q && !rsp.ready) |=> (state_q == ST_EMIT))
		else $error("response loaded over a pending word");

endmodule

[test/lpg_checker.sv]
// Checker for the lexicographic permutation generator: watches the request,
// response and length channels, predicts every response word and compares it.
// Depends on lpg_pkg and the channel interfaces in lpg_channels.sv.
module lpg_checker (
	input  logic clk,
	input  logic arst_n,
	lpg_req_if   req,
	lpg_rsp_if   rsp,
	lpg_cfg_if   cfg,
	output int   fail_count,
	output int   words_pending
);

	localparam int MAX_ELEMS = 16;
	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		lpg_pkg::word_t word;
		logic           is_final;
		logic           exhausted;
	} perm_result_t;

	// Predicted state: stored order, end-of-sequence mark and length register
	lpg_pkg::elem_t perm_order [MAX_ELEMS];
	logic           seq_ended;
	lpg_pkg::len_t  length_reg;
	perm_result_t   expected_words [$];

	task automatic report_mismatch(string what);
		fail_count++;
		if (fail_count <= MAX_PRINTED)
			$display("[%0t] lpg_checker: %s", $time, what);
	endtask

	// Register value 0 acts as 1, anything above 16 acts as 16
	function automatic int active_length();
		int n;
		n = int'(length_reg);
		if (n < 1)
			n = 1;
		if (n > MAX_ELEMS)
			n = MAX_ELEMS;
		return n;
	endfunction

	function automatic void reload_identity();
		for (int k = 0; k < MAX_ELEMS; k++)
			perm_order[k] = lpg_pkg::elem_t'(k);
		seq_ended = 1'b0;
	endfunction

	// Next permutation in place; returns 0 when the order is already descending
	function automatic bit step_to_successor(int n);
		int             p, q, lo, hi;
		bit             found;
		lpg_pkg::elem_t t;
		found = 1'b0;
		p = 0;
		// rightmost ascent
		for (q = n - 1; q > 0; q--) begin
			if (!found && perm_order[q-1] < perm_order[q]) begin
				p = q - 1;
				found = 1'b1;
			end
		end
		if (!found)
			return 1'b0;
		// rightmost element larger than the pivot
		q = n - 1;
		while (q > p + 1 && perm_order[q] < perm_order[p])
			q--;
		t = perm_order[p];
		perm_order[p] = perm_order[q];
		perm_order[q] = t;
		// reverse the suffix
		lo = p + 1;
		hi = n - 1;
		while (hi > lo) begin
			t = perm_order[lo];
			perm_order[lo] = perm_order[hi];
			perm_order[hi] = t;
			lo++;
			hi--;
		end
		return 1'b1;
	endfunction

	function automatic perm_result_t next_permutation_word(logic restart);
		perm_result_t r;
		int           n;
		n = active_length();
		if (restart)
			reload_identity();
		r = '0;
		if (seq_ended) begin
			r.exhausted = 1'b1;
			return r;
		end
		for (int k = 0; k < n; k++)
			r.word[lpg_pkg::ELEM_W*k +: lpg_pkg::ELEM_W] = perm_order[k];
		r.is_final = !step_to_successor(n);
		if (r.is_final)
			seq_ended = 1'b1;
		return r;
	endfunction

	// Track config and requests, compare each accepted response word
	always @(posedge clk or negedge arst_n) begin
		perm_result_t want;
		if (!arst_n) begin
			length_reg = lpg_pkg::LEN_RESET;
			reload_identity();
			expected_words.delete();
			fail_count = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				length_reg = cfg.length;
				reload_identity();
			end
			if (req.valid && req.ready)
				expected_words.push_back(next_permutation_word(req.restart));
			if (rsp.valid && rsp.ready) begin
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("unexpected response word %h",
						rsp.permutation_word));
				end else begin
					want = expected_words.pop_front();
					if (rsp.permutation_word !== want.word)
						report_mismatch($sformatf("permutation_word %h, expected %h",
							rsp.permutation_word, want.word));
					if (rsp.is_final !== want.is_final)
						report_mismatch($sformatf("is_final %b, expected %b (word %h)",
							rsp.is_final, want.is_final, want.word));
					if (rsp.exhausted !== want.exhausted)
						report_mismatch($sformatf("exhausted %b, expected %b (word %h)",
							rsp.exhausted, want.exhausted, want.word));
				end
			end
		end
		words_pending = expected_words.size();
	end

endmodule

[test/tb_lex_permutation_generator.sv]
// Testbench top for the lexicographic permutation generator: clock, reset,
// request/length stimulus, response back-pressure and the verdict.
// Depends on lpg_pkg, lpg_channels.sv, the block and lpg_checker.
module tb_lex_permutation_generator;

	typedef enum int {SINK_ALWAYS, SINK_RANDOM, SINK_BURSTY} sink_mode_t;

	localparam int RANDOM_WORDS    = 1250;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 60;
	localparam int DIRECTED_LENS   = 6;

	logic clk;
	logic arst_n;

	lpg_req_if req ();
	lpg_rsp_if rsp ();
	lpg_cfg_if cfg ();

	int         fail_count;
	int         words_pending;
	sink_mode_t sink_mode   = SINK_BURSTY;
	bit         hold_off_req = 1'b0;
	bit         sender_gaps  = 1'b1;
	int         burst_left   = 8;

	lex_permutation_generator #(.MAX_ELEMENTS(16)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	lpg_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.rsp           (rsp),
		.cfg           (cfg),
		.fail_count    (fail_count),
		.words_pending (words_pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Limit on the whole run
	initial begin
		#10_000_000;
		$display("FAIL lex_permutation_generator");
		$finish;
	end

	// Response side: long hold-off on request, otherwise the current stall pattern
	initial begin
		int stall_run;
		stall_run = 0;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				rsp.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				case (sink_mode)
					SINK_ALWAYS: rsp.ready <= 1'b1;
					SINK_RANDOM: rsp.ready <= ($urandom_range(0, 99) < 60);
					default: begin
						if (stall_run > 0) begin
							rsp.ready <= 1'b0;
							stall_run--;
						end else begin
							rsp.ready <= 1'b1;
							if ($urandom_range(0, 3) == 0)
								stall_run = $urandom_range(1, 20);
						end
					end
				endcase
			end
		end
	end

	// One request word; valid stays high into the next word inside a burst
	task automatic send_request(logic restart_bit);
		int gap;
		req.valid   <= 1'b1;
		req.restart <= restart_bit;
		do @(posedge clk); while (!req.ready);
		if (sender_gaps) begin
			burst_left--;
			if (burst_left <= 0) begin
				gap = ($urandom_range(0, 9) == 0) ?
					$urandom_range(11, 40) : $urandom_range(1, 10);
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(1, 16);
			end
		end
	endtask

	// Stop sending and wait for every outstanding response word
	task automatic drain_responses();
		req.valid <= 1'b0;
		do @(posedge clk); while (words_pending != 0);
	endtask

	task automatic write_length(lpg_pkg::len_t value);
		cfg.valid  <= 1'b1;
		cfg.length <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	// Mostly short lengths so sequences run out; extremes now and then
	function automatic lpg_pkg::len_t pick_length();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return lpg_pkg::len_t'($urandom_range(1, 4));
		if (r < 16)
			return lpg_pkg::len_t'($urandom_range(5, 8));
		if (r < 18)
			return lpg_pkg::len_t'($urandom_range(9, 16));
		if (r == 18)
			return ($urandom_range(0, 1) != 0) ? 5'd31 : 5'd0;
		return lpg_pkg::len_t'($urandom_range(17, 30));
	endfunction

	initial begin
		lpg_pkg::len_t dir_len [DIRECTED_LENS];
		int   n_dir;
		int   phase;
		int   words;
		int   restart_odds;
		int   random_sent;

		dir_len = '{5'd1, 5'd2, 5'd0, 5'd16, 5'd31, 5'd17};
		arst_n      = 1'b0;
		req.valid   = 1'b0;
		req.restart = 1'b0;
		cfg.valid   = 1'b0;
		cfg.length  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset order at length 6, then short, zero, full and oversized lengths
		repeat (3) send_request(1'b0);
		send_request(1'b1);
		drain_responses();
		for (int i = 0; i < DIRECTED_LENS; i++) begin
			write_length(dir_len[i]);
			n_dir = (dir_len[i] <= 2) ? 4 : 3;
			for (int j = 0; j < n_dir; j++)
				send_request(j == n_dir - 1);
			drain_responses();
		end

		// Random phases of request words
		phase = 0;
		random_sent = 0;
		while (random_sent < RANDOM_WORDS) begin
			phase++;
			sink_mode   = sink_mode_t'($urandom_range(0, 2));
			sender_gaps = ($urandom_range(0, 3) != 0);
			if (phase == 2) begin
				// full rate, no idling on either side
				sink_mode   = SINK_ALWAYS;
				sender_gaps = 1'b0;
			end
			if (phase == 1 || $urandom_range(0, 2) != 0)
				write_length(pick_length());
			words = $urandom_range(20, 100);
			case ($urandom_range(0, 2))
				0:       restart_odds = 0;
				1:       restart_odds = 64;
				default: restart_odds = 12;
			endcase
			if (phase == 3) begin
				// receiver holds off while the sender keeps offering words
				sink_mode    = SINK_ALWAYS;
				sender_gaps  = 1'b0;
				words        = 60;
				hold_off_req = 1'b1;
			end
			for (int i = 0; i < words; i++) begin
				send_request(restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
				random_sent++;
			end
			drain_responses();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS lex_permutation_generator");
		else
			$display("FAIL lex_permutation_generator");
		$finish;
	end

endmodule
